### sv/nhd_pkg.sv
package nhd_pkg;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_DIGEST = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Final status codes, in order of precedence after OK.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_LINE_END = 3'd1,
    ST_NAME_LONG   = 3'd2,
    ST_TOO_SHORT   = 3'd3,
    ST_BAD_DIGIT   = 3'd4
  } status_e;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_NAME   = 3'b001,
    PH_SKIP   = 3'b010,
    PH_DIGEST = 3'b100
  } phase_e;

  localparam logic [6:0] DigitCount = 7'd96;
  localparam logic [6:0] TailNeed   = 7'd97;

  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] TenOffset  = 8'd10;

  // One result word as it travels from the parser to the output stage.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] position;
    logic [7:0] value;
    status_e    status;
  } word_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  // Decode one ASCII hex digit in either case.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok     = 1'b1;
    r.nibble = 4'd0;
    if (c >= CharZero && c <= CharNine) begin
      r.nibble = 4'(c - CharZero);
    end else if (c >= CharLowerA && c <= CharLowerF) begin
      r.nibble = 4'(c - CharLowerA + TenOffset);
    end else if (c >= CharUpperA && c <= CharUpperF) begin
      r.nibble = 4'(c - CharUpperA + TenOffset);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### sv/nhd_core.sv
module nhd_core #(
  parameter int NAME_STORE = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          is_last_i,
  output logic          res_valid_o,
  output nhd_pkg::word_t res_o
);
  import nhd_pkg::*;

  localparam int NW = $clog2(NAME_STORE);
  localparam logic [NW-1:0] NameEmitMax = NW'(NAME_STORE - 2);
  localparam logic [NW-1:0] NameSat     = NW'(NAME_STORE - 1);

  phase_e        phase_q, phase_d;
  logic [NW-1:0] name_len_q, name_len_d;
  logic [6:0]    digit_q, digit_d;
  logic [3:0]    high_q, high_d;
  logic [6:0]    tail_q, tail_d;
  logic          bad_q, bad_d;

  logic       line_end;
  logic       have;
  hex_t       hex;
  logic [7:0] name_len_ext;
  word_t      res;

  assign line_end     = (in_byte_i == CharCr) || (in_byte_i == CharLf);
  assign hex          = hex_decode(in_byte_i);
  assign name_len_ext = 8'(name_len_q);

  // Next state and result for the byte on the input.
  always_comb begin
    phase_d    = phase_q;
    name_len_d = name_len_q;
    digit_d    = digit_q;
    high_d     = high_q;
    tail_d     = tail_q;
    bad_d      = bad_q;
    have       = 1'b0;
    res        = '{kind: KIND_NAME, position: 6'd0, value: 8'd0, status: ST_OK};

    // Name line and the run of line ends after it.
    unique case (phase_q)
      PH_NAME: begin
        if (line_end) begin
          phase_d = PH_SKIP;
        end else begin
          if (name_len_q < NameEmitMax) begin
            have         = 1'b1;
            res.kind     = KIND_NAME;
            res.position = name_len_ext[5:0];
            res.value    = in_byte_i;
          end
          if (name_len_q < NameSat) begin
            name_len_d = name_len_q + 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (!line_end) begin
          phase_d = PH_DIGEST;
        end
      end
      PH_DIGEST: begin
      end
      default: begin
        phase_d = PH_NAME;
      end
    endcase

    // Digest digits and the tail length.
    if (phase_d == PH_DIGEST && !(line_end && tail_q == 7'd0)) begin
      if (tail_q < TailNeed) begin
        tail_d = tail_q + 7'd1;
      end
      if (!bad_q && digit_q < DigitCount) begin
        if (!hex.ok) begin
          bad_d = 1'b1;
        end else begin
          if (!digit_q[0]) begin
            high_d = hex.nibble;
          end else begin
            have         = 1'b1;
            res.kind     = KIND_DIGEST;
            res.position = digit_q[6:1];
            res.value    = {high_q, hex.nibble};
          end
          digit_d = digit_q + 7'd1;
        end
      end
    end

    // The last byte gives only the status and returns the parser to reset.
    if (is_last_i) begin
      have         = 1'b1;
      res.kind     = KIND_STATUS;
      res.position = 6'd0;
      res.value    = 8'd0;
      priority if (phase_d == PH_NAME) begin
        res.status = ST_NO_LINE_END;
      end else if (name_len_d > NameEmitMax) begin
        res.status = ST_NAME_LONG;
      end else if (tail_d < TailNeed) begin
        res.status = ST_TOO_SHORT;
      end else if (bad_d || digit_d < DigitCount) begin
        res.status = ST_BAD_DIGIT;
      end else begin
        res.status = ST_OK;
      end
      phase_d    = PH_NAME;
      name_len_d = '0;
      digit_d    = 7'd0;
      high_d     = 4'd0;
      tail_d     = 7'd0;
      bad_d      = 1'b0;
    end
  end

  assign res_valid_o = accept_i && have;
  assign res_o       = res;

  // Parser state, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME;
      name_len_q <= '0;
      digit_q    <= 7'd0;
      high_q     <= 4'd0;
      tail_q     <= 7'd0;
      bad_q      <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      name_len_q <= name_len_d;
      digit_q    <= digit_d;
      high_q     <= high_d;
      tail_q     <= tail_d;
      bad_q      <= bad_d;
    end
  end

  // The digit and tail counters saturate at their limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= DigitCount && tail_q <= TailNeed)
    else $error("digest counters beyond their limits");

  // A digit can only be packed while the tail is being counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q != 7'd0 |-> tail_q >= digit_q)
    else $error("digit count ahead of tail count");

  // The last byte of a file always returns the parser to its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_last_i |=> phase_q == PH_NAME && name_len_q == '0 &&
      digit_q == 7'd0 && tail_q == 7'd0 && !bad_q)
    else $error("parser not cleared after the last byte");

  // Counting the tail means the parser is in the digest phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q != 7'd0 |-> phase_q == PH_DIGEST)
    else $error("tail counted outside the digest phase");

endmodule

### sv/nhd_out_reg.sv
module nhd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  nhd_pkg::word_t word_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nhd_pkg::word_t word_o
);
  import nhd_pkg::*;

  logic  valid_q, valid_d;
  word_t word_q;

  // A new byte may enter whenever the held word leaves in this cycle.
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

  // A loaded word is offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded word not offered");

  // A word is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || out_ready_i)
    else $error("waiting word overwritten");

endmodule

### sv/name_and_hex_digest_parser_top.sv
// Name and hex digest parser.
// The input channel (in_valid_i, in_ready_o) takes a text file one byte per
// word, with is_last_i set on its final byte. The first line is a file name;
// each name byte is sent out with its index while the name fits. After the
// run of CR and LF bytes, 96 hex digits are packed into 48 digest bytes, each
// sent out as it completes. The last byte gives one status word only.
// The output channel (out_valid_o, out_ready_i) carries kind_o, position_o,
// value_o and status_o. A byte gives zero or one result word.
// An accepted byte's result word is offered from the output register in the
// next cycle. Throughput is one byte per cycle unless a held word waits on
// the receiver: the parser state is a small update done in the accepting cycle.
// When the receiver stalls, the result word holds in the output register and
// in_ready_o drops only while that word is held and out_ready_i is low.
// Reset clears the parser to the start of a file and empties the output.
module name_and_hex_digest_parser_top #(
  parameter int NAME_STORE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [5:0] position_o,
  output logic [7:0] value_o,
  output logic [2:0] status_o
);
  import nhd_pkg::*;

  logic  accept;
  logic  res_valid;
  word_t res_word;
  word_t out_word;

  assign accept = in_valid_i && in_ready_o;

  // Parser state and per-byte logic.
  nhd_core #(
    .NAME_STORE(NAME_STORE)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .res_valid_o(res_valid),
    .res_o      (res_word)
  );

  // Result register toward the receiver.
  nhd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .word_i     (res_word),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .word_o     (out_word)
  );

  assign kind_o     = out_word.kind;
  assign position_o = out_word.position;
  assign value_o    = out_word.value;
  assign status_o   = out_word.status;

endmodule
